FILE: rtl/core/gdm_pkg.sv
// shared types and constants for the greedy detection matcher
package gdm_pkg;

    localparam int MAX_GT_DEFAULT = 64;
    localparam int ID_W = 64;
    localparam int AREA_W = 32;
    localparam int IOU_W = 17;
    localparam int SLOT_W = 6;
    localparam logic [IOU_W-1:0] IOU_ONE = 17'd65536;
    localparam logic [IOU_W-1:0] IOU_CLAMP = 17'd65535;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD_GT = 2'd1,
        OP_LOAD_IOU = 2'd2,
        OP_SCAN = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REG_IOU_THRESHOLD = 2'd0,
        REG_AREA_MIN = 2'd1,
        REG_AREA_MAX = 2'd2
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PASS0,
        ST_PASS1,
        ST_DONE
    } state_t;

    // running best handed from cell to cell
    typedef struct packed {
        logic found;
        logic [IOU_W-1:0] best;
        logic [SLOT_W-1:0] slot;
        logic [ID_W-1:0] gt_id;
        logic excl;
    } best_t;

endpackage

FILE: rtl/core/greedy_detection_matcher.sv
// top level of the greedy detection matcher
// channel | dir | handshake            | payload
// s_axis  | in  | s_axis_tvalid/tready | op, id, area, flags, slot, overlap
// m_axis  | out | m_axis_tvalid/tready | detection result
// cfg     | in  | cfg_valid/cfg_ready  | register index and data
// ops 0, 1, 2 complete when accepted; a scan steps through the table one
// cell per cycle, with a second pass over excluded entries when the first
// finds nothing, then waits in the done state until the output register is free
// reset clears the table count and taken bits and sets the registers to defaults; stores are undefined
// a result waits in the output register while the next item is accepted
module greedy_detection_matcher #(
    parameter int MAX_GT = gdm_pkg::MAX_GT_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // op[1:0], item_id[65:2], item_area[97:66], skip_flag[98], crowd_flag[99],
    // gt_slot[105:100], overlap[122:106], zero fill to 128
    input  logic [127:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // detection_id[63:0], match_found[64], matched_gt_id[128:65],
    // matched_slot[134:129], detection_ignored[135], matched_overlap[152:136]
    output logic [159:0] m_axis_tdata,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [31:0] cfg_data
);
    localparam int SLOT_BITS = (MAX_GT > 1) ? $clog2(MAX_GT) : 1;
    localparam logic [SLOT_BITS:0] MAX_COUNT = (SLOT_BITS+1)'(MAX_GT);
    localparam logic [SLOT_BITS-1:0] LAST_POS = SLOT_BITS'(MAX_GT - 1);

    logic [gdm_pkg::IOU_W-1:0] thr_reg;
    logic [gdm_pkg::AREA_W-1:0] amin_reg;
    logic [gdm_pkg::AREA_W-1:0] amax_reg;
    logic [SLOT_BITS:0] count_reg;
    gdm_pkg::state_t state_reg, state_next;
    logic [SLOT_BITS-1:0] pos_reg, pos_next;
    gdm_pkg::best_t best_reg, best_next, chain_out;
    logic [gdm_pkg::ID_W-1:0] det_id_reg;
    logic det_ign_reg;
    logic out_valid_reg;
    logic [159:0] out_data_reg;

    gdm_pkg::op_t op;
    logic [gdm_pkg::ID_W-1:0] in_id;
    logic [gdm_pkg::AREA_W-1:0] in_area;
    logic in_skip, in_crowd;
    logic [5:0] in_slot;
    logic [gdm_pkg::IOU_W-1:0] in_ov, ov_sat;
    logic accept, load, iou_we, clear, take, finish, in_area_out;
    logic [gdm_pkg::IOU_W-1:0] thr_clamped;

    assign op = gdm_pkg::op_t'(s_axis_tdata[1:0]);
    assign in_id = s_axis_tdata[65:2];
    assign in_area = s_axis_tdata[97:66];
    assign in_skip = s_axis_tdata[98];
    assign in_crowd = s_axis_tdata[99];
    assign in_slot = s_axis_tdata[105:100];
    assign in_ov = s_axis_tdata[122:106];
    assign ov_sat = (in_ov > gdm_pkg::IOU_ONE) ? gdm_pkg::IOU_ONE : in_ov;
    assign thr_clamped = (thr_reg > gdm_pkg::IOU_CLAMP) ? gdm_pkg::IOU_CLAMP : thr_reg;
    assign in_area_out = (in_area < amin_reg) || (in_area > amax_reg);

    assign s_axis_tready = (state_reg == gdm_pkg::ST_IDLE);
    assign accept = s_axis_tvalid && s_axis_tready;
    assign clear = accept && (op == gdm_pkg::OP_CLEAR);
    assign load = accept && (op == gdm_pkg::OP_LOAD_GT) && (count_reg < MAX_COUNT);
    assign iou_we = accept && (op == gdm_pkg::OP_LOAD_IOU)
                    && ({1'b0, in_slot} < 7'(MAX_GT));
    assign cfg_ready = 1'b1;
    assign finish = (state_reg == gdm_pkg::ST_DONE) && (!out_valid_reg || m_axis_tready);
    assign take = finish && best_reg.found;

    gdm_chain #(.MAX_GT(MAX_GT), .SLOT_BITS(SLOT_BITS)) u_chain (
        .clk(clk),
        .rst_n(rst_n),
        .clear(clear),
        .load(load),
        .load_pos(count_reg),
        .load_id(in_id),
        .load_excl(in_skip || in_area_out),
        .load_crowd(in_crowd),
        .iou_we(iou_we),
        .iou_pos(SLOT_BITS'(in_slot)),
        .iou_value(ov_sat),
        .scan_en((state_reg == gdm_pkg::ST_PASS0) || (state_reg == gdm_pkg::ST_PASS1)),
        .scan_pos(pos_reg),
        .want_excl(state_reg == gdm_pkg::ST_PASS1),
        .gt_count(count_reg),
        .take(take),
        .take_pos(best_reg.slot[SLOT_BITS-1:0]),
        .best_in(best_reg),
        .best_out(chain_out)
    );

    always_comb
    begin
        state_next = state_reg;
        pos_next = pos_reg;
        best_next = best_reg;
        unique case (state_reg)
            gdm_pkg::ST_IDLE:
            begin
                if (accept && (op == gdm_pkg::OP_SCAN))
                begin
                    best_next = '0;
                    best_next.best = thr_clamped;
                    pos_next = '0;
                    state_next = gdm_pkg::ST_PASS0;
                end
            end
            gdm_pkg::ST_PASS0:
            begin
                best_next = chain_out;
                pos_next = pos_reg + 1'b1;
                if (pos_reg == LAST_POS)
                begin
                    pos_next = '0;
                    state_next = chain_out.found ? gdm_pkg::ST_DONE : gdm_pkg::ST_PASS1;
                end
            end
            gdm_pkg::ST_PASS1:
            begin
                best_next = chain_out;
                pos_next = pos_reg + 1'b1;
                if (pos_reg == LAST_POS)
                begin
                    pos_next = '0;
                    state_next = gdm_pkg::ST_DONE;
                end
            end
            gdm_pkg::ST_DONE:
            begin
                if (finish)
                begin
                    state_next = gdm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gdm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gdm_pkg::ST_IDLE;
            pos_reg <= '0;
            count_reg <= '0;
            out_valid_reg <= 1'b0;
            thr_reg <= 17'd32768;
            amin_reg <= '0;
            amax_reg <= '1;
            best_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg <= pos_next;
            best_reg <= best_next;
            if (clear)
            begin
                count_reg <= '0;
            end
            else if (load)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (gdm_pkg::reg_index_t'(cfg_index))
                    gdm_pkg::REG_IOU_THRESHOLD: thr_reg <= cfg_data[gdm_pkg::IOU_W-1:0];
                    gdm_pkg::REG_AREA_MIN: amin_reg <= cfg_data;
                    gdm_pkg::REG_AREA_MAX: amax_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (op == gdm_pkg::OP_SCAN))
        begin
            det_id_reg <= in_id;
            det_ign_reg <= in_skip || in_area_out;
        end
        if (finish)
        begin
            out_data_reg <= {7'd0,
                best_reg.found ? best_reg.best : {gdm_pkg::IOU_W{1'b0}},
                best_reg.found ? best_reg.excl : det_ign_reg,
                best_reg.found ? best_reg.slot : {gdm_pkg::SLOT_W{1'b0}},
                best_reg.found ? best_reg.gt_id : {gdm_pkg::ID_W{1'b0}},
                best_reg.found,
                det_id_reg};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_data_reg;

`ifndef ASSERT_OFF
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> (state_reg == gdm_pkg::ST_IDLE))
        else $error("input ready outside idle");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_COUNT)
        else $error("table count overflow");
    a_take_found: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> (best_reg.best >= thr_clamped))
        else $error("match below threshold");
    a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> m_axis_tvalid)
        else $error("result lost");
`endif
endmodule

FILE: rtl/core/gdm_cell.sv
// one ground-truth cell: holds its entry and updates the running best
module gdm_cell #(
    parameter int SLOT_BITS = 6,
    parameter int INDEX = 0
) (
    input  logic clk,
    input  logic rst_n,
    input  logic clear,
    input  logic load,
    input  logic [gdm_pkg::ID_W-1:0] load_id,
    input  logic load_excl,
    input  logic load_crowd,
    input  logic iou_we,
    input  logic [gdm_pkg::IOU_W-1:0] iou_value,
    input  logic scan_en,
    input  logic want_excl,
    input  logic active,
    input  logic take,
    input  gdm_pkg::best_t best_in,
    output gdm_pkg::best_t best_out
);
    logic [gdm_pkg::ID_W-1:0] id_reg;
    logic excl_reg;
    logic crowd_reg;
    logic taken_reg;
    logic [gdm_pkg::IOU_W-1:0] iou_reg;
    logic eligible;
    localparam logic [SLOT_BITS-1:0] MY_IDX = SLOT_BITS'(INDEX);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            id_reg <= load_id;
            excl_reg <= load_excl;
            crowd_reg <= load_crowd;
        end
        if (iou_we)
        begin
            iou_reg <= iou_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taken_reg <= 1'b0;
        end
        else if (clear || load)
        begin
            taken_reg <= 1'b0;
        end
        else if (take)
        begin
            taken_reg <= 1'b1;
        end
    end

    assign eligible = scan_en && active && (excl_reg == want_excl)
                      && !(taken_reg && !crowd_reg) && (iou_reg >= best_in.best);

    always_comb
    begin
        best_out = best_in;
        if (eligible)
        begin
            best_out.found = 1'b1;
            best_out.best = iou_reg;
            best_out.slot = gdm_pkg::SLOT_W'(MY_IDX);
            best_out.gt_id = id_reg;
            best_out.excl = excl_reg;
        end
    end
endmodule

FILE: rtl/core/gdm_chain.sv
// row of cells; the cell selected by scan_pos updates the best given in, one cell per cycle
module gdm_chain #(
    parameter int MAX_GT = gdm_pkg::MAX_GT_DEFAULT,
    parameter int SLOT_BITS = (MAX_GT > 1) ? $clog2(MAX_GT) : 1
) (
    input  logic clk,
    input  logic rst_n,
    input  logic clear,
    input  logic load,
    input  logic [SLOT_BITS:0] load_pos,
    input  logic [gdm_pkg::ID_W-1:0] load_id,
    input  logic load_excl,
    input  logic load_crowd,
    input  logic iou_we,
    input  logic [SLOT_BITS-1:0] iou_pos,
    input  logic [gdm_pkg::IOU_W-1:0] iou_value,
    input  logic scan_en,
    input  logic [SLOT_BITS-1:0] scan_pos,
    input  logic want_excl,
    input  logic [SLOT_BITS:0] gt_count,
    input  logic take,
    input  logic [SLOT_BITS-1:0] take_pos,
    input  gdm_pkg::best_t best_in,
    output gdm_pkg::best_t best_out
);
    gdm_pkg::best_t link [MAX_GT];

    for (genvar g = 0; g < MAX_GT; g++)
    begin : g_cell
        localparam logic [SLOT_BITS-1:0] IDX = SLOT_BITS'(g);
        gdm_cell #(.SLOT_BITS(SLOT_BITS), .INDEX(g)) u_cell (
            .clk(clk),
            .rst_n(rst_n),
            .clear(clear),
            .load(load && (load_pos == {1'b0, IDX})),
            .load_id(load_id),
            .load_excl(load_excl),
            .load_crowd(load_crowd),
            .iou_we(iou_we && (iou_pos == IDX)),
            .iou_value(iou_value),
            .scan_en(scan_en && (scan_pos == IDX)),
            .want_excl(want_excl),
            .active({1'b0, IDX} < gt_count),
            .take(take && (take_pos == IDX)),
            .best_in(best_in),
            .best_out(link[g])
        );
    end

    always_comb
    begin
        best_out = best_in;
        for (int g = 0; g < MAX_GT; g++)
        begin
            if (scan_pos == SLOT_BITS'(g))
            begin
                best_out = link[g];
            end
        end
    end
endmodule

FILE: bench/greedy_detection_matcher_tb.sv
// testbench for the greedy detection matcher: directed table and random sequences
`timescale 1ns / 1ps

module greedy_detection_matcher_tb;

    localparam int TABLE_SIZE = 64;
    localparam int SETTLE = 2 * TABLE_SIZE + 20;
    localparam int STALL_LIMIT = 5000;

    typedef struct packed {
        logic [gdm_pkg::IOU_W-1:0] overlap;
        logic [gdm_pkg::SLOT_W-1:0] slot;
        logic crowd;
        logic skip;
        logic [gdm_pkg::AREA_W-1:0] area;
        logic [gdm_pkg::ID_W-1:0] id;
        gdm_pkg::op_t op;
    } req_t;

    typedef struct packed {
        logic [gdm_pkg::IOU_W-1:0] overlap;
        logic ignored;
        logic [gdm_pkg::SLOT_W-1:0] slot;
        logic [gdm_pkg::ID_W-1:0] gt_id;
        logic found;
        logic [gdm_pkg::ID_W-1:0] det_id;
    } match_t;

    typedef struct {
        req_t req;
        bit typed;
        bit exp_found;
        bit exp_ignored;
    } row_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [159:0] m_axis_tdata;
    logic cfg_valid;
    logic cfg_ready;
    logic [1:0] cfg_index;
    logic [31:0] cfg_data;

    // predictor copy of the matcher state
    logic [gdm_pkg::IOU_W-1:0] thr_q;
    logic [gdm_pkg::AREA_W-1:0] amin_q;
    logic [gdm_pkg::AREA_W-1:0] amax_q;
    int gt_loaded;
    logic [gdm_pkg::ID_W-1:0] gt_id_mem [TABLE_SIZE];
    bit gt_excl_mem [TABLE_SIZE];
    bit gt_crowd_mem [TABLE_SIZE];
    bit gt_taken_mem [TABLE_SIZE];
    logic [gdm_pkg::IOU_W-1:0] iou_mem [TABLE_SIZE];

    match_t pending_matches[$];
    row_t dir_rows[$];
    int errors = 0;
    int scans_seen = 0;
    int matches_seen = 0;
    int sent_items;
    bit src_idle_en;
    bit snk_idle_en;
    bit hold_armed = 1'b0;
    bit hold_done = 1'b0;
    int snk_hold = 0;
    int quiet_cycles = 0;

    greedy_detection_matcher dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic bit area_out(logic [gdm_pkg::AREA_W-1:0] a);
        return a < amin_q || a > amax_q;
    endfunction

    task automatic report(string what);
        errors++;
        $display("error at %0t: %s", $realtime, what);
    endtask

    // updates the state copy and returns the expected match for a scan
    function automatic void apply_item(req_t r, output bit has_res, output match_t res);
        logic [gdm_pkg::IOU_W-1:0] best;
        bit found;
        int pick;
        has_res = 0;
        res = '0;
        case (r.op)
            gdm_pkg::OP_CLEAR:
            begin
                gt_loaded = 0;
                foreach (gt_taken_mem[i]) gt_taken_mem[i] = 0;
            end
            gdm_pkg::OP_LOAD_GT:
            begin
                if (gt_loaded < TABLE_SIZE)
                begin
                    gt_id_mem[gt_loaded] = r.id;
                    gt_excl_mem[gt_loaded] = r.skip || area_out(r.area);
                    gt_crowd_mem[gt_loaded] = r.crowd;
                    gt_taken_mem[gt_loaded] = 0;
                    gt_loaded++;
                end
            end
            gdm_pkg::OP_LOAD_IOU:
                iou_mem[r.slot] = (r.overlap > gdm_pkg::IOU_ONE) ? gdm_pkg::IOU_ONE
                                                                 : r.overlap;
            default:
            begin
                best = (thr_q > gdm_pkg::IOU_CLAMP) ? gdm_pkg::IOU_CLAMP : thr_q;
                found = 0;
                pick = 0;
                for (int pass = 0; pass < 2; pass++)
                begin
                    if (pass == 1 && found)
                        break;
                    for (int g = 0; g < gt_loaded; g++)
                    begin
                        if (gt_excl_mem[g] != (pass == 1))
                            continue;
                        if (gt_taken_mem[g] && !gt_crowd_mem[g])
                            continue;
                        if (iou_mem[g] >= best)
                        begin
                            best = iou_mem[g];
                            pick = g;
                            found = 1;
                        end
                    end
                end
                has_res = 1;
                res.det_id = r.id;
                res.found = found;
                if (found)
                begin
                    gt_taken_mem[pick] = 1;
                    res.gt_id = gt_id_mem[pick];
                    res.slot = pick[gdm_pkg::SLOT_W-1:0];
                    res.overlap = best;
                    res.ignored = gt_excl_mem[pick];
                end
                else
                    res.ignored = area_out(r.area) || r.skip;
            end
        endcase
    endfunction

    task automatic send(req_t r, output match_t res, output bit has_res);
        while (src_idle_en && $urandom_range(99) < 26)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'd0, r};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        apply_item(r, has_res, res);
        if (has_res)
            pending_matches.insert(pending_matches.size(), res);
        sent_items++;
    endtask

    task automatic push(req_t r);
        match_t res;
        bit has_res;
        send(r, res, has_res);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_matches.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(gdm_pkg::reg_index_t idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            gdm_pkg::REG_IOU_THRESHOLD: thr_q = val[gdm_pkg::IOU_W-1:0];
            gdm_pkg::REG_AREA_MIN: amin_q = val;
            default: amax_q = val;
        endcase
        @(posedge clk);
    endtask

    function automatic req_t mk(gdm_pkg::op_t op, logic [gdm_pkg::ID_W-1:0] id,
                                logic [gdm_pkg::AREA_W-1:0] area,
                                bit skip, bit crowd, logic [gdm_pkg::SLOT_W-1:0] slot,
                                logic [gdm_pkg::IOU_W-1:0] ov);
        req_t r;
        r.op = op;
        r.id = id;
        r.area = area;
        r.skip = skip;
        r.crowd = crowd;
        r.slot = slot;
        r.overlap = ov;
        return r;
    endfunction

    function automatic void add_row(req_t r, bit typed, bit exp_found, bit exp_ignored);
        row_t x;
        x.req = r;
        x.typed = typed;
        x.exp_found = exp_found;
        x.exp_ignored = exp_ignored;
        dir_rows.insert(dir_rows.size(), x);
    endfunction

    function automatic logic [gdm_pkg::AREA_W-1:0] rnd_area();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            2: return amin_q;
            3: return amax_q;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [gdm_pkg::IOU_W-1:0] rnd_iou();
        case ($urandom_range(7))
            0: return '0;
            1: return gdm_pkg::IOU_ONE;
            2: return 17'h1FFFF;
            3: return thr_q;
            4: return gdm_pkg::IOU_CLAMP;
            default: return 17'($urandom_range(17'h1FFFF));
        endcase
    endfunction

    function automatic logic [gdm_pkg::ID_W-1:0] rnd_id();
        return {$urandom, $urandom};
    endfunction

    // one image: optional clear, ground truth, then per detection its overlaps, at times a random op, and the scan
    task automatic run_image();
        int n_gt;
        int n_det;
        if ($urandom_range(3) != 0)
            push(mk(gdm_pkg::OP_CLEAR, rnd_id(), rnd_area(), 1'($urandom_range(1)),
                    1'($urandom_range(1)), 6'($urandom_range(63)), rnd_iou()));
        n_gt = ($urandom_range(40) == 0) ? TABLE_SIZE + 2 : $urandom_range(8);
        repeat (n_gt)
            push(mk(gdm_pkg::OP_LOAD_GT, rnd_id(), rnd_area(), $urandom_range(3) == 0,
                    $urandom_range(2) == 0, 6'($urandom_range(63)), rnd_iou()));
        n_det = $urandom_range(1, 5);
        repeat (n_det)
        begin
            for (int g = 0; g < gt_loaded && g < 10; g++)
                if ($urandom_range(4) != 0)
                    push(mk(gdm_pkg::OP_LOAD_IOU, rnd_id(), rnd_area(),
                            1'($urandom_range(1)), 1'($urandom_range(1)),
                            g[gdm_pkg::SLOT_W-1:0], rnd_iou()));
            if ($urandom_range(9) == 0)
                push(mk(gdm_pkg::op_t'($urandom_range(3)), rnd_id(), rnd_area(),
                        1'($urandom_range(1)), 1'($urandom_range(1)),
                        6'($urandom_range(63)), rnd_iou()));
            push(mk(gdm_pkg::OP_SCAN, rnd_id(), rnd_area(), $urandom_range(3) == 0,
                    1'($urandom_range(1)), 6'($urandom_range(63)), rnd_iou()));
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_armed && !hold_done)
        begin
            m_axis_tready <= 1'b0;
            snk_hold <= 400;
            hold_done <= 1'b1;
        end
        else if (snk_hold > 0)
        begin
            m_axis_tready <= 1'b0;
            snk_hold <= snk_hold - 1;
        end
        else
            m_axis_tready <= !(snk_idle_en && $urandom_range(99) < 26);
    end

    always @(posedge clk)
    begin
        match_t got;
        match_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[152:0];
            if (pending_matches.size() == 0)
                report("result with nothing expected");
            else
            begin
                want = pending_matches.pop_front();
                scans_seen++;
                if (got.found)
                    matches_seen++;
                if (got.det_id !== want.det_id)
                    report($sformatf("detection_id %h, want %h", got.det_id, want.det_id));
                if (got.found !== want.found)
                    report($sformatf("match_found %b, want %b", got.found, want.found));
                if (got.gt_id !== want.gt_id)
                    report($sformatf("matched_gt_id %h, want %h", got.gt_id, want.gt_id));
                if (got.slot !== want.slot)
                    report($sformatf("matched_slot %0d, want %0d", got.slot, want.slot));
                if (got.ignored !== want.ignored)
                    report($sformatf("detection_ignored %b, want %b", got.ignored,
                                     want.ignored));
                if (got.overlap !== want.overlap)
                    report($sformatf("matched_overlap %h, want %h", got.overlap,
                                     want.overlap));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT)
        begin
            $display("greedy_detection_matcher: mismatch");
            $finish;
        end
    end

    initial
    begin
        match_t res;
        bit has_res;
        logic [31:0] phase_cfg [6][3];

        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sent_items = 0;
        src_idle_en = 1;
        snk_idle_en = 1;
        thr_q = 17'd32768;
        amin_q = '0;
        amax_q = '1;
        gt_loaded = 0;
        foreach (gt_taken_mem[i]) gt_taken_mem[i] = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every iou slot gets a value before any scan can read it
        for (int s = 0; s < TABLE_SIZE; s++)
            push(mk(gdm_pkg::OP_LOAD_IOU, '0, '0, 1'b0, 1'b0, s[gdm_pkg::SLOT_W-1:0], '0));

        add_row(mk(gdm_pkg::OP_SCAN, '1, '0, 1'b0, 1'b0, '0, '0), 1'b1, 1'b0, 1'b0);
        add_row(mk(gdm_pkg::OP_SCAN, 64'd7, '1, 1'b1, 1'b1, '1, '1), 1'b1, 1'b0, 1'b1);
        add_row(mk(gdm_pkg::OP_LOAD_GT, 64'hAAAA_5555_AAAA_5555, '1, 1'b0, 1'b0, '0, '0),
                1'b0, 1'b0, 1'b0);
        add_row(mk(gdm_pkg::OP_LOAD_GT, 64'h1, '0, 1'b1, 1'b0, '1, '1), 1'b0, 1'b0, 1'b0);
        add_row(mk(gdm_pkg::OP_LOAD_GT, 64'h5555_AAAA_5555_AAAA, 32'h8000, 1'b0, 1'b1,
                   '0, '0), 1'b0, 1'b0, 1'b0);
        add_row(mk(gdm_pkg::OP_LOAD_IOU, '0, '0, 1'b0, 1'b0, 6'd0, gdm_pkg::IOU_ONE),
                1'b0, 1'b0, 1'b0);
        add_row(mk(gdm_pkg::OP_LOAD_IOU, '0, '0, 1'b0, 1'b0, 6'd1, 17'h1FFFF),
                1'b0, 1'b0, 1'b0);
        add_row(mk(gdm_pkg::OP_LOAD_IOU, '0, '0, 1'b0, 1'b0, 6'd2, 17'd32768),
                1'b0, 1'b0, 1'b0);
        add_row(mk(gdm_pkg::OP_SCAN, 64'd10, '0, 1'b0, 1'b0, '0, '0), 1'b1, 1'b1, 1'b0);
        add_row(mk(gdm_pkg::OP_SCAN, 64'd11, '0, 1'b0, 1'b0, '0, '0), 1'b1, 1'b1, 1'b0);
        add_row(mk(gdm_pkg::OP_SCAN, 64'd12, '0, 1'b1, 1'b0, '0, '0), 1'b1, 1'b1, 1'b0);
        add_row(mk(gdm_pkg::OP_LOAD_IOU, '0, '0, 1'b0, 1'b0, 6'd2, 17'd0),
                1'b0, 1'b0, 1'b0);
        add_row(mk(gdm_pkg::OP_SCAN, 64'd13, '0, 1'b0, 1'b0, '0, '0), 1'b1, 1'b1, 1'b1);
        add_row(mk(gdm_pkg::OP_SCAN, 64'd14, '1, 1'b0, 1'b0, '0, '0), 1'b1, 1'b0, 1'b0);
        add_row(mk(gdm_pkg::OP_CLEAR, '1, '1, 1'b1, 1'b1, '1, '1), 1'b0, 1'b0, 1'b0);
        add_row(mk(gdm_pkg::OP_SCAN, 64'd15, '0, 1'b0, 1'b0, '0, '0), 1'b1, 1'b0, 1'b0);
        foreach (dir_rows[i])
        begin
            send(dir_rows[i].req, res, has_res);
            if (dir_rows[i].typed && (res.found !== dir_rows[i].exp_found
                                      || res.ignored !== dir_rows[i].exp_ignored))
                report($sformatf("table row %0d found %b ignored %b", i, res.found,
                                 res.ignored));
        end
        drain();

        phase_cfg = '{'{32'd32768, 32'd0, 32'hFFFF_FFFF},
                      '{32'd65536, 32'd0, 32'hFFFF_FFFF},
                      '{32'd0, 32'h0001_0000, 32'h8000_0000},
                      '{32'd65535, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
                      '{32'd1, 32'd0, 32'd0},
                      '{32'd40000, 32'h1234_5678, 32'h9ABC_DEF0}};
        for (int p = 0; p < 6; p++)
        begin
            write_reg(gdm_pkg::REG_IOU_THRESHOLD, phase_cfg[p][0]);
            write_reg(gdm_pkg::REG_AREA_MIN, phase_cfg[p][1]);
            write_reg(gdm_pkg::REG_AREA_MAX, phase_cfg[p][2]);
            src_idle_en = (p != 2);
            snk_idle_en = (p != 2);
            if (p == 3)
                hold_armed = 1'b1;
            while (sent_items < 64 + 16 + (p + 1) * 170)
                run_image();
            drain();
        end

        $display("%0d items sent over 6 register settings", sent_items);
        $display("%0d detection results checked, %0d of them matched", scans_seen,
                 matches_seen);
        if (errors == 0)
            $display("greedy_detection_matcher: match");
        else
            $display("greedy_detection_matcher: mismatch");
        $finish;
    end

endmodule
